>>> rtl/xcfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcfc_pkg
// Shared constants and codes for the XOR-checked frame codec.
// ----------------------------------------------------------------------------
package xcfc_pkg;

  localparam int BUF_DEPTH = 1024;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);

  localparam int REQ_W  = 2;
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 10;
  localparam int MAX_W  = 11;
  localparam int STAT_W = 2;
  localparam int DSZ_W  = 16;
  localparam int PSZ_W  = 17;
  localparam int POS_W  = 17;
  localparam int LEN_W  = 16;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [MAX_W-1:0]  MAX_LIMIT  = MAX_W'(BUF_DEPTH);
  localparam logic [BYTE_W-1:0] TOK_START  = 8'h24;
  localparam logic [BYTE_W-1:0] TOK_STOP   = 8'h42;
  localparam logic [POS_W-1:0]  WRAP_BYTES = 17'd6;

  localparam logic [REQ_W-1:0] REQ_RX    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TX    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_BUSY  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOBUF = 2'd2;

endpackage
`default_nettype wire

>>> rtl/xor_checked_frame_codec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xor_checked_frame_codec
// Receives and transmits length-prefixed frames with an XOR checksum,
// through a 1024-byte frame buffer that the host can also access.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tuser: req_type; tdata: byte_in, buf_addr
// m_axis    out  m_axis_tvalid/tready      tuser: status; tdata: byte_out, sizes
// cfg       in   cfg_valid/cfg_ready       cfg_data: max_size
//
// A new beat is accepted in every cycle unless the output is stalled.
// A result appears in the cycle after its beat is accepted, held in the output register.
// The buffer's read port is registered in step with the output register.
// Input stalls only while a result is waiting and m_axis_tready is low.
// Reset is synchronous and clears all control state; the buffer is not cleared.
module xor_checked_frame_codec (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] byte_in, [17:8] buf_addr, [23:18] zero
  input  wire logic [xcfc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  wire logic [xcfc_pkg::REQ_W-1:0] s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] byte_out, [23:8] data_size, [40:24] packet_size, [47:41] zero
  output logic [xcfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [xcfc_pkg::STAT_W-1:0] m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [xcfc_pkg::MAX_W-1:0] cfg_data
);

  logic [xcfc_pkg::MAX_W-1:0]  max_size;
  logic [xcfc_pkg::POS_W-1:0]  position;
  logic [xcfc_pkg::LEN_W-1:0]  frame_length;
  logic [xcfc_pkg::LEN_W-1:0]  rx_check;
  logic [xcfc_pkg::BYTE_W-1:0] running_xor;
  logic                        xor_pend;
  logic                        output_mode;
  logic                        frame_done;

  logic [xcfc_pkg::BYTE_W-1:0] frame_buffer [xcfc_pkg::BUF_DEPTH];
  logic [xcfc_pkg::BYTE_W-1:0] mem_q;

  logic                        out_valid;
  logic [xcfc_pkg::STAT_W-1:0] out_status;
  logic [xcfc_pkg::BYTE_W-1:0] out_byte;
  logic                        out_use_q;
  logic [xcfc_pkg::DSZ_W-1:0]  out_dsz;
  logic [xcfc_pkg::PSZ_W-1:0]  out_psz;

  logic [xcfc_pkg::POS_W-1:0]  position_next;
  logic [xcfc_pkg::LEN_W-1:0]  frame_length_next;
  logic [xcfc_pkg::LEN_W-1:0]  rx_check_next;
  logic [xcfc_pkg::BYTE_W-1:0] running_xor_next;
  logic                        xor_pend_next;
  logic                        output_mode_next;
  logic                        frame_done_next;
  logic [xcfc_pkg::STAT_W-1:0] status_next;
  logic [xcfc_pkg::BYTE_W-1:0] byte_next;
  logic                        use_q_next;
  logic [xcfc_pkg::DSZ_W-1:0]  dsz_next;
  logic [xcfc_pkg::PSZ_W-1:0]  psz_next;

  logic                        mem_we;
  logic                        mem_re;
  logic [xcfc_pkg::BUF_AW-1:0] mem_addr;
  logic [xcfc_pkg::BYTE_W-1:0] mem_wdata;

  logic                        accept;
  logic [xcfc_pkg::REQ_W-1:0]  req_type;
  logic [xcfc_pkg::BYTE_W-1:0] byte_in;
  logic [xcfc_pkg::ADDR_W-1:0] buf_addr;
  logic [xcfc_pkg::BYTE_W-1:0] xor_eff;
  logic [xcfc_pkg::POS_W-1:0]  len_p3;
  logic [xcfc_pkg::POS_W-1:0]  len_p4;
  logic [xcfc_pkg::POS_W-1:0]  len_p5;
  logic [xcfc_pkg::POS_W-1:0]  pos_idx;
  logic                        in_data;
  logic                        ok;
  logic [xcfc_pkg::POS_W-1:0]  pos_adv;
  logic [xcfc_pkg::MAX_W-1:0]  cfg_sat;

  assign req_type = s_axis_tuser;
  assign byte_in  = s_axis_tdata[7:0];
  assign buf_addr = s_axis_tdata[17:8];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign cfg_sat       = (cfg_data > xcfc_pkg::MAX_LIMIT) ? xcfc_pkg::MAX_LIMIT : cfg_data;

  // A buffer byte read for transmit joins the checksum one beat later.
  assign xor_eff = xor_pend ? (running_xor ^ mem_q) : running_xor;

  assign len_p3  = {1'b0, frame_length} + 17'd3;
  assign len_p4  = {1'b0, frame_length} + 17'd4;
  assign len_p5  = {1'b0, frame_length} + 17'd5;
  assign pos_idx = position - 17'd3;
  assign in_data = (position > 17'd2) && (position < len_p3);

  always_comb begin
    position_next     = position;
    frame_length_next = frame_length;
    rx_check_next     = rx_check;
    running_xor_next  = xor_eff;
    xor_pend_next     = 1'b0;
    output_mode_next  = output_mode;
    frame_done_next   = frame_done;
    status_next       = xcfc_pkg::STAT_BUSY;
    byte_next         = '0;
    use_q_next        = 1'b0;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    mem_addr          = pos_idx[xcfc_pkg::BUF_AW-1:0];
    mem_wdata         = byte_in;
    ok                = 1'b1;
    pos_adv           = position;

    case (req_type)
      xcfc_pkg::REQ_RX: begin
        if (max_size == '0) begin
          status_next = xcfc_pkg::STAT_NOBUF;
        end else begin
          output_mode_next = 1'b0;
          frame_done_next  = 1'b0;
          if (in_data) begin
            mem_we           = 1'b1;
            running_xor_next = xor_eff ^ byte_in;
          end else if (position == 17'd0) begin
            ok = (byte_in == xcfc_pkg::TOK_START);
          end else if (position == 17'd1) begin
            frame_length_next = {8'h00, byte_in};
          end else if (position == 17'd2) begin
            frame_length_next = frame_length + {byte_in, 8'h00};
            ok = (frame_length_next != '0) &&
                 (frame_length_next <= {5'b0, max_size});
            running_xor_next = '0;
          end else if (position == len_p3) begin
            ok = (byte_in == xcfc_pkg::TOK_STOP);
          end else if (position == len_p4) begin
            rx_check_next = {8'h00, byte_in};
          end else if (position == len_p5) begin
            rx_check_next = rx_check + {byte_in, 8'h00};
            ok = (rx_check_next == {8'h00, xor_eff});
          end
          if (ok) begin
            pos_adv = position + 17'd1;
          end else begin
            pos_adv           = '0;
            frame_length_next = '0;
          end
          position_next = pos_adv;
          if ((pos_adv > 17'd5) && (pos_adv == {1'b0, frame_length_next} + 17'd6)) begin
            frame_done_next = 1'b1;
            position_next   = '0;
          end
          status_next = frame_done_next ? xcfc_pkg::STAT_DONE : xcfc_pkg::STAT_BUSY;
        end
      end
      xcfc_pkg::REQ_TX: begin
        output_mode_next = 1'b1;
        frame_done_next  = 1'b0;
        if (in_data) begin
          mem_re        = 1'b1;
          use_q_next    = 1'b1;
          xor_pend_next = 1'b1;
        end else if (position == 17'd0) begin
          byte_next         = xcfc_pkg::TOK_START;
          frame_length_next = {5'b0, max_size};
        end else if (position == 17'd1) begin
          byte_next = frame_length[7:0];
        end else if (position == 17'd2) begin
          byte_next        = frame_length[15:8];
          running_xor_next = '0;
        end else if (position == len_p3) begin
          byte_next = xcfc_pkg::TOK_STOP;
        end else if (position == len_p4) begin
          byte_next = xor_eff;
        end
        pos_adv       = position + 17'd1;
        position_next = pos_adv;
        if ((pos_adv > 17'd5) && (pos_adv == {1'b0, frame_length_next} + 17'd6)) begin
          frame_done_next = 1'b1;
          position_next   = '0;
        end
        status_next = frame_done_next ? xcfc_pkg::STAT_DONE : xcfc_pkg::STAT_BUSY;
      end
      xcfc_pkg::REQ_WRITE: begin
        mem_we    = 1'b1;
        mem_addr  = buf_addr[xcfc_pkg::BUF_AW-1:0];
      end
      default: begin
        mem_re     = 1'b1;
        use_q_next = 1'b1;
        mem_addr   = buf_addr[xcfc_pkg::BUF_AW-1:0];
      end
    endcase

    if (output_mode_next) begin
      dsz_next = {5'b0, max_size};
      psz_next = frame_done_next ? '0 :
                 (xcfc_pkg::WRAP_BYTES + {6'b0, max_size} - position_next);
    end else begin
      dsz_next = frame_done_next ? frame_length_next : '0;
      psz_next = frame_done_next ? (xcfc_pkg::WRAP_BYTES + {1'b0, frame_length_next}) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      frame_buffer[mem_addr] <= mem_wdata;
    end
    if (accept && mem_re) begin
      mem_q <= frame_buffer[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size     <= '0;
      position     <= '0;
      frame_length <= '0;
      rx_check     <= '0;
      running_xor  <= '0;
      xor_pend     <= 1'b0;
      output_mode  <= 1'b0;
      frame_done   <= 1'b0;
    end else if (cfg_valid) begin
      max_size     <= cfg_sat;
      position     <= '0;
      frame_length <= '0;
      rx_check     <= '0;
      running_xor  <= '0;
      xor_pend     <= 1'b0;
      output_mode  <= (cfg_sat != '0);
      frame_done   <= 1'b0;
    end else if (accept) begin
      position     <= position_next;
      frame_length <= frame_length_next;
      rx_check     <= rx_check_next;
      running_xor  <= running_xor_next;
      xor_pend     <= xor_pend_next;
      output_mode  <= output_mode_next;
      frame_done   <= frame_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_byte   <= byte_next;
      out_use_q  <= use_q_next;
      out_dsz    <= dsz_next;
      out_psz    <= psz_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {7'b0, out_psz, out_dsz, (out_use_q ? mem_q : out_byte)};

endmodule
`default_nettype wire

>>> rtl/xcfc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// xcfc_checker
// Port-level checks for the XOR-checked frame codec.
// ----------------------------------------------------------------------------
module xcfc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [xcfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [xcfc_pkg::STAT_W-1:0] m_axis_tuser
);

  logic [xcfc_pkg::DSZ_W-1:0] dsz;
  logic [xcfc_pkg::PSZ_W-1:0] psz;

  assign dsz = m_axis_tdata[23:8];
  assign psz = m_axis_tdata[40:24];

  // Every accepted beat yields its result in the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  // A completed frame reports either a received length or a finished transmit.
  a_done_sizes: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == xcfc_pkg::STAT_DONE) |->
      (psz == '0) || (psz == {1'b0, dsz} + 17'd6))
    else $error("inconsistent sizes on a completed frame");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == xcfc_pkg::STAT_BUSY) ||
      (m_axis_tuser == xcfc_pkg::STAT_DONE) || (m_axis_tuser == xcfc_pkg::STAT_NOBUF))
    else $error("undefined status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind xor_checked_frame_codec xcfc_checker u_xcfc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

>>> tb/tb_xor_checked_frame_codec.sv
// ----------------------------------------------------------------------------
// Testbench for the XOR-checked frame codec
// Drives request beats (receive, transmit, host write and host read) through
// the input stream under several buffer sizes, predicts every result beat with
// a cycle-free model of the frame parser and generator, and compares each
// result field by field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_xor_checked_frame_codec;

  localparam int POS_MASK = 'h1FFFF;

  typedef struct packed {
    logic [xcfc_pkg::STAT_W-1:0] status;
    logic [xcfc_pkg::BYTE_W-1:0] byte_out;
    logic [xcfc_pkg::DSZ_W-1:0]  data_size;
    logic [xcfc_pkg::PSZ_W-1:0]  packet_size;
  } codec_result_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_START,
    FLAW_LEN_ZERO,
    FLAW_LEN_HIGH,
    FLAW_STOP,
    FLAW_SUM,
    FLAW_SUM_HIGH
  } frame_flaw_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [xcfc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [xcfc_pkg::REQ_W-1:0]      s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [xcfc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [xcfc_pkg::STAT_W-1:0]     m_axis_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [xcfc_pkg::MAX_W-1:0]      cfg_data;

  int                          limit_q;
  int                          pos_q;
  int                          len_q;
  int                          rx_sum_q;
  int                          xor_q;
  bit                          tx_mode_q;
  bit                          done_q;
  logic [xcfc_pkg::BYTE_W-1:0] frame_mem [xcfc_pkg::BUF_DEPTH];
  bit                          mem_set [xcfc_pkg::BUF_DEPTH];
  codec_result_t               pending_results [$];
  int                          errors;
  int                          items_sent;
  bit                          steady;

  xor_checked_frame_codec i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic bit in_payload();
    return pos_q > 2 && pos_q < len_q + 3;
  endfunction

  function automatic void store_byte(input int idx, input logic [xcfc_pkg::BYTE_W-1:0] v);
    if (idx < xcfc_pkg::BUF_DEPTH) begin
      frame_mem[idx] = v;
      mem_set[idx] = 1'b1;
    end
  endfunction

  function automatic bit frame_closed();
    if (pos_q > 5 && pos_q == len_q + 6) begin
      done_q = 1'b1;
      pos_q = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic codec_result_t next_codec_result(
      input logic [xcfc_pkg::REQ_W-1:0]  req,
      input logic [xcfc_pkg::BYTE_W-1:0] b,
      input logic [xcfc_pkg::ADDR_W-1:0] addr);
    codec_result_t r;
    bit ok;
    int old_len;
    int v;
    int psz;
    r = '0;
    old_len = len_q;
    v = 0;
    psz = 0;
    case (req)
      xcfc_pkg::REQ_RX: begin
        if (limit_q == 0) begin
          r.status = xcfc_pkg::STAT_NOBUF;
        end else begin
          ok = 1'b1;
          tx_mode_q = 1'b0;
          done_q = 1'b0;
          if (in_payload()) begin
            store_byte(pos_q - 3, b);
            xor_q = xor_q ^ int'(b);
          end else if (pos_q == 0) begin
            ok = (b == xcfc_pkg::TOK_START);
          end else if (pos_q == 1) begin
            len_q = int'(b);
          end else if (pos_q == 2) begin
            len_q = (len_q + (int'(b) << 8)) & 'hFFFF;
            ok = len_q > 0 && len_q <= limit_q;
            xor_q = 0;
          end else if (pos_q == old_len + 3) begin
            ok = (b == xcfc_pkg::TOK_STOP);
          end else if (pos_q == old_len + 4) begin
            rx_sum_q = int'(b);
          end else if (pos_q == old_len + 5) begin
            rx_sum_q = (rx_sum_q + (int'(b) << 8)) & 'hFFFF;
            ok = (rx_sum_q == xor_q);
          end
          if (ok) begin
            pos_q = (pos_q + 1) & POS_MASK;
          end else begin
            pos_q = 0;
            len_q = 0;
          end
          r.status = frame_closed() ? xcfc_pkg::STAT_DONE : xcfc_pkg::STAT_BUSY;
        end
      end
      xcfc_pkg::REQ_TX: begin
        tx_mode_q = 1'b1;
        done_q = 1'b0;
        if (in_payload()) begin
          v = (pos_q - 3 < xcfc_pkg::BUF_DEPTH) ? int'(frame_mem[pos_q - 3]) : 0;
          xor_q = xor_q ^ v;
        end else if (pos_q == 0) begin
          v = int'(xcfc_pkg::TOK_START);
          len_q = limit_q;
        end else if (pos_q == 1) begin
          v = len_q & 'hFF;
        end else if (pos_q == 2) begin
          v = (len_q >> 8) & 'hFF;
          xor_q = 0;
        end else if (pos_q == old_len + 3) begin
          v = int'(xcfc_pkg::TOK_STOP);
        end else if (pos_q == old_len + 4) begin
          v = xor_q & 'hFF;
        end else if (pos_q == old_len + 5) begin
          v = (xor_q >> 8) & 'hFF;
        end
        r.byte_out = v[xcfc_pkg::BYTE_W-1:0];
        pos_q = (pos_q + 1) & POS_MASK;
        r.status = frame_closed() ? xcfc_pkg::STAT_DONE : xcfc_pkg::STAT_BUSY;
      end
      xcfc_pkg::REQ_WRITE: begin
        store_byte(int'(addr), b);
      end
      default: begin
        r.byte_out = frame_mem[addr];
      end
    endcase
    if (!tx_mode_q) begin
      if (done_q) begin
        psz = int'(xcfc_pkg::WRAP_BYTES) + len_q;
        r.data_size = len_q[xcfc_pkg::DSZ_W-1:0];
        r.packet_size = psz[xcfc_pkg::PSZ_W-1:0];
      end
    end else begin
      r.data_size = limit_q[xcfc_pkg::DSZ_W-1:0];
      if (!done_q) begin
        psz = int'(xcfc_pkg::WRAP_BYTES) + limit_q - pos_q;
        r.packet_size = psz[xcfc_pkg::PSZ_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic send_item(input logic [xcfc_pkg::REQ_W-1:0] req,
                           input logic [xcfc_pkg::BYTE_W-1:0] b,
                           input logic [xcfc_pkg::ADDR_W-1:0] addr);
    int gap;
    int slot;
    logic [xcfc_pkg::REQ_W-1:0] kind;
    logic [xcfc_pkg::ADDR_W-1:0] where;
    kind = req;
    where = addr;
    slot = pos_q - 3;
    // A beat that would read a buffer entry never written becomes a write of it.
    if (req == xcfc_pkg::REQ_READ && !mem_set[addr]) begin
      kind = xcfc_pkg::REQ_WRITE;
    end else if (req == xcfc_pkg::REQ_TX && in_payload() && !mem_set[slot]) begin
      kind = xcfc_pkg::REQ_WRITE;
      where = slot[xcfc_pkg::ADDR_W-1:0];
    end
    if ($urandom_range(0, 39) == 0) begin
      steady = !steady;
    end
    gap = draw_wait();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, where, b};
    s_axis_tuser <= kind;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(next_codec_result(kind, b, where));
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_max(input logic [xcfc_pkg::MAX_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_q = (value > xcfc_pkg::MAX_LIMIT) ? int'(xcfc_pkg::MAX_LIMIT) : int'(value);
    pos_q = 0;
    len_q = 0;
    rx_sum_q = 0;
    xor_q = 0;
    done_q = 1'b0;
    tx_mode_q = (limit_q != 0);
  endtask

  task automatic send_rx_frame(input int len, input frame_flaw_t flaw);
    logic [xcfc_pkg::BYTE_W-1:0] line [$];
    logic [xcfc_pkg::BYTE_W-1:0] sum;
    logic [xcfc_pkg::BYTE_W-1:0] d;
    int field;
    field = len;
    if (flaw == FLAW_LEN_ZERO) begin
      field = 0;
    end else if (flaw == FLAW_LEN_HIGH) begin
      field = $urandom_range(limit_q + 1, 65535);
    end
    sum = '0;
    line.push_back(flaw == FLAW_START ?
                   xcfc_pkg::TOK_START ^ 8'($urandom_range(1, 255)) : xcfc_pkg::TOK_START);
    line.push_back(field[7:0]);
    line.push_back(field[15:8]);
    repeat (len) begin
      d = 8'($urandom);
      line.push_back(d);
      sum = sum ^ d;
    end
    line.push_back(flaw == FLAW_STOP ?
                   xcfc_pkg::TOK_STOP ^ 8'($urandom_range(1, 255)) : xcfc_pkg::TOK_STOP);
    line.push_back(flaw == FLAW_SUM ? sum ^ 8'($urandom_range(1, 255)) : sum);
    line.push_back(flaw == FLAW_SUM_HIGH ? 8'($urandom_range(1, 255)) : 8'h00);
    foreach (line[i]) begin
      send_item(xcfc_pkg::REQ_RX, line[i], 10'($urandom));
    end
  endtask

  task automatic send_tx_frame();
    do send_item(xcfc_pkg::REQ_TX, 8'($urandom), 10'($urandom)); while (pos_q != 0);
  endtask

  task automatic run_mixed_traffic(input int count);
    int stop_at;
    int pick;
    int span;
    int len;
    frame_flaw_t flaw;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      span = (limit_q == 0) ? 8 : (limit_q < 24) ? limit_q : 24;
      if (pick <= 3) begin
        if (limit_q != 0 && limit_q <= 64 && $urandom_range(0, 7) == 0) begin
          len = limit_q;
        end else begin
          len = $urandom_range(1, span);
        end
        flaw = FLAW_NONE;
        if ($urandom_range(0, 3) == 0) begin
          flaw = frame_flaw_t'($urandom_range(int'(FLAW_START), int'(FLAW_SUM_HIGH)));
        end
        send_rx_frame(len, flaw);
      end else if (pick <= 5 && limit_q <= 64) begin
        send_tx_frame();
      end else if (pick <= 5) begin
        repeat ($urandom_range(1, 4)) send_item(xcfc_pkg::REQ_TX, 8'($urandom), 10'($urandom));
      end else if (pick == 6) begin
        send_item(xcfc_pkg::REQ_WRITE, 8'($urandom),
                  $urandom_range(0, 1) ? 10'($urandom_range(0, 63)) : 10'($urandom));
      end else if (pick == 7) begin
        send_item(xcfc_pkg::REQ_READ, 8'($urandom),
                  $urandom_range(0, 1) ? 10'($urandom_range(0, 63)) : 10'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) send_item(2'($urandom), 8'($urandom), 10'($urandom));
      end
    end
  endtask

  task automatic test_no_buffer();
    send_item(xcfc_pkg::REQ_RX, xcfc_pkg::TOK_START, 10'd0);
    send_item(xcfc_pkg::REQ_RX, 8'hFF, 10'h3FF);
    send_tx_frame();
    send_item(xcfc_pkg::REQ_RX, xcfc_pkg::TOK_START, 10'd5);
  endtask

  task automatic test_host_access();
    send_item(xcfc_pkg::REQ_WRITE, 8'h00, 10'd0);
    send_item(xcfc_pkg::REQ_WRITE, 8'hFF, 10'h3FF);
    send_item(xcfc_pkg::REQ_READ, 8'h00, 10'd0);
    send_item(xcfc_pkg::REQ_READ, 8'h00, 10'h3FF);
  endtask

  task automatic test_smallest_frame();
    logic [xcfc_pkg::BYTE_W-1:0] line [7];
    line = '{xcfc_pkg::TOK_START, 8'h01, 8'h00, 8'hFF, xcfc_pkg::TOK_STOP, 8'hFF, 8'h00};
    write_max(11'd1);
    foreach (line[i]) begin
      send_item(xcfc_pkg::REQ_RX, line[i], 10'd0);
    end
    send_tx_frame();
  endtask

  task automatic test_full_buffer();
    write_max('1);
    send_rx_frame(16, FLAW_NONE);
    repeat (12) send_item(xcfc_pkg::REQ_TX, 8'($urandom), 10'($urandom));
    send_item(xcfc_pkg::REQ_WRITE, 8'hA5, 10'h3FF);
    send_item(xcfc_pkg::REQ_READ, 8'h00, 10'h3FF);
  endtask

  task automatic test_random_traffic();
    write_max(11'd1);
    run_mixed_traffic(60);
    repeat (4) begin
      write_max(11'($urandom_range(2, 40)));
      run_mixed_traffic(70);
    end
    write_max(xcfc_pkg::MAX_LIMIT);
    run_mixed_traffic(40);
    write_max(11'($urandom_range(xcfc_pkg::BUF_DEPTH + 1, 2047)));
    run_mixed_traffic(20);
    write_max(11'd0);
    run_mixed_traffic(40);
  endtask

  initial begin : result_monitor
    int stall;
    codec_result_t got;
    codec_result_t want;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.status = m_axis_tuser;
      got.byte_out = m_axis_tdata[7:0];
      got.data_size = m_axis_tdata[23:8];
      got.packet_size = m_axis_tdata[40:24];
      if (pending_results.size() == 0) begin
        $error("Result beat arrived with no expectation pending.");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.byte_out !== want.byte_out) begin
          $error("byte_out: expected %0d, got %0d", want.byte_out, got.byte_out);
          errors++;
        end
        if (got.data_size !== want.data_size) begin
          $error("data_size: expected %0d, got %0d", want.data_size, got.data_size);
          errors++;
        end
        if (got.packet_size !== want.packet_size) begin
          $error("packet_size: expected %0d, got %0d", want.packet_size, got.packet_size);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_no_buffer();
    test_host_access();
    test_smallest_frame();
    test_full_buffer();
    test_random_traffic();
    wait_idle();
    if (errors == 0) begin
      $display("PASS xor_checked_frame_codec");
    end else begin
      $display("FAIL xor_checked_frame_codec");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL xor_checked_frame_codec");
    $finish;
  end

endmodule

>>> xor_checked_frame_codec.f
rtl/xcfc_pkg.sv
rtl/xor_checked_frame_codec.sv
rtl/xcfc_checker.sv
tb/tb_xor_checked_frame_codec.sv
